// ----- hdl/nfd_pkg.sv -----
// Shared constants and types for the normalized fractional divider.
`default_nettype none
package nfd_pkg;

  localparam int OPERAND_W     = 32;
  localparam int MAG_W         = OPERAND_W - 1;
  localparam int LEAD_W        = 5;
  localparam int QUOTIENT_BITS = 15;
  localparam int QUOTIENT_W    = 17;
  localparam int SHIFT_W       = 6;
  localparam int NUM_TOP_W     = 14;
  localparam int DEN_TOP_W     = 15;
  localparam int REM_W         = DEN_TOP_W + 1;

  localparam int QUEUE_DEPTH   = 4;
  localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

  localparam int OB_DEPTH      = 2;
  localparam int OB_PTR_W      = $clog2(OB_DEPTH);
  localparam int OB_CNT_W      = $clog2(OB_DEPTH + 1);

  localparam logic [QUOTIENT_W-1:0] DIV_ZERO_QUOTIENT = 17'h0FFFF;
  localparam logic [SHIFT_W-1:0]    DIV_ZERO_SHIFT    = 6'd15;

  // One normalized item on its way through the divide iterations.
  typedef struct packed {
    logic [REM_W-1:0]         rem;
    logic [DEN_TOP_W-1:0]     dvsr;
    logic [QUOTIENT_BITS-1:0] quo;
    logic signed [SHIFT_W-1:0] shift;
    logic                     neg;
    logic                     num_zero;
    logic                     den_zero;
  } work_t;

  typedef struct packed {
    logic signed [QUOTIENT_W-1:0] quotient;
    logic signed [SHIFT_W-1:0]    shift_exponent;
  } result_t;

endpackage
`default_nettype wire

// ----- hdl/normalized_fractional_divider.sv -----
// Normalized fractional divider: signed 32/32 divide giving a Q15 quotient and an exponent.
//
// Input channel: an item (in_numerator, in_denominator) is taken at a rising edge where
// push is high and full is low. Result channel: while empty is low the oldest result sits
// on out_quotient and out_shift_exponent; it is taken at an edge where pop is high.
// The quotient is the signed Q15 magnitude of |num|/|den| after both are normalized;
// out_shift_exponent is the left shift that restores the true ratio. A zero numerator
// gives 0 and 0; a zero denominator gives 65535 with the numerator's sign and shift 15.
// Path: an item passes three front stages for magnitude, leading count and normalize,
// the queue, one stage per quotient bit for the 15 restoring steps, a sign stage and
// the output buffer. Throughput: one item per cycle while results are popped, set by
// the fully pipelined divide stages. When pop is held low the output buffer fills,
// the divide stages stop, the four-entry queue fills and then full rises; no item is
// dropped. Reset is synchronous and active low; it empties every stage and buffer, and
// push is honored on the next cycle.
`default_nettype none
module normalized_fractional_divider import nfd_pkg::*; (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic signed [OPERAND_W-1:0]  in_numerator,
  input  wire logic signed [OPERAND_W-1:0]  in_denominator,
  output logic                              empty,
  input  wire logic                         pop,
  output logic signed [QUOTIENT_W-1:0]      out_quotient,
  output logic signed [SHIFT_W-1:0]         out_shift_exponent
);

  logic    q_push, q_full, q_pop, q_empty;
  work_t   q_wdata, q_rdata;
  result_t result;

  nfd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_i   (push),
    .full_o   (full),
    .num_i    (in_numerator),
    .den_i    (in_denominator),
    .q_push_o (q_push),
    .q_data_o (q_wdata),
    .q_full_i (q_full)
  );

  nfd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  nfd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data_i  (q_rdata),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .empty_o   (empty),
    .pop_i     (pop),
    .result_o  (result)
  );

  assign out_quotient       = result.quotient;
  assign out_shift_exponent = result.shift_exponent;

endmodule
`default_nettype wire

// ----- hdl/nfd_front.sv -----
// Front end: takes items, forms saturated magnitudes, leading counts and normalized operands.
`default_nettype none
module nfd_front import nfd_pkg::*; (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push_i,
  output logic                             full_o,
  input  wire logic signed [OPERAND_W-1:0] num_i,
  input  wire logic signed [OPERAND_W-1:0] den_i,
  output logic                             q_push_o,
  output work_t                            q_data_o,
  input  wire logic                        q_full_i
);

  typedef struct packed {
    logic [MAG_W-1:0] num_mag;
    logic [MAG_W-1:0] den_mag;
    logic             neg;
    logic             num_zero;
    logic             den_zero;
  } mag_t;

  typedef struct packed {
    mag_t              mag;
    logic [LEAD_W-1:0] num_lead;
    logic [LEAD_W-1:0] den_lead;
  } lead_t;

  // Number of left shifts that bring the top set bit to bit 30, capped at 30.
  function automatic logic [LEAD_W-1:0] lead_count(input logic [MAG_W-1:0] v);
    logic [LEAD_W-1:0] cnt;
    cnt = LEAD_W'(MAG_W - 1);
    for (int i = 0; i < MAG_W; i++) begin
      if (v[i]) begin
        cnt = LEAD_W'(MAG_W - 1 - i);
      end
    end
    return cnt;
  endfunction

  function automatic logic [MAG_W-1:0] sat_mag(input logic [OPERAND_W-1:0] v);
    logic [OPERAND_W-1:0] negv;
    negv = ~v + 1'b1;
    if (!v[OPERAND_W-1]) begin
      return v[MAG_W-1:0];
    end else if (v[MAG_W-1:0] == '0) begin
      return '1;
    end else begin
      return negv[MAG_W-1:0];
    end
  endfunction

  logic  adv;
  logic  s1_v_r, s2_v_r, s3_v_r;
  mag_t  s1_r;
  mag_t  s1_nxt;
  lead_t s2_r;
  lead_t s2_nxt;
  work_t s3_r;
  work_t s3_nxt;
  logic [MAG_W-1:0] num_norm, den_norm;

  // The whole front moves together unless its last stage waits on a full queue.
  assign adv      = !(s3_v_r && q_full_i);
  assign full_o   = !adv;
  assign q_push_o = s3_v_r && !q_full_i;
  assign q_data_o = s3_r;

  always_comb begin
    s1_nxt.num_zero = (num_i == '0);
    s1_nxt.den_zero = (den_i == '0);
    s1_nxt.neg      = s1_nxt.den_zero ? num_i[OPERAND_W-1]
                                      : (num_i[OPERAND_W-1] ^ den_i[OPERAND_W-1]);
    s1_nxt.num_mag  = sat_mag(num_i);
    s1_nxt.den_mag  = sat_mag(den_i);
  end

  always_comb begin
    s2_nxt.mag      = s1_r;
    s2_nxt.num_lead = lead_count(s1_r.num_mag);
    s2_nxt.den_lead = lead_count(s1_r.den_mag);
  end

  always_comb begin
    num_norm          = s2_r.mag.num_mag << s2_r.num_lead;
    den_norm          = s2_r.mag.den_mag << s2_r.den_lead;
    s3_nxt.rem        = REM_W'(num_norm[MAG_W-1 -: NUM_TOP_W]);
    s3_nxt.dvsr       = den_norm[MAG_W-1 -: DEN_TOP_W];
    s3_nxt.quo        = '0;
    s3_nxt.shift      = SHIFT_W'({1'b0, s2_r.den_lead}) - SHIFT_W'({1'b0, s2_r.num_lead})
                        + SHIFT_W'(1);
    s3_nxt.neg        = s2_r.mag.neg;
    s3_nxt.num_zero   = s2_r.mag.num_zero;
    s3_nxt.den_zero   = s2_r.mag.den_zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= push_i;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/nfd_queue.sv -----
// Short queue of normalized items between the front end and the divide pipeline.
`default_nettype none
module nfd_queue import nfd_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push_i,
  input  work_t      data_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output work_t      data_o,
  output logic       empty_o
);

  work_t                  mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_CNT_W-1:0] cnt_r;
  logic                   do_push, do_pop;

  assign full_o  = (cnt_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_r == '0);
  assign data_o  = mem_r[rd_ptr_r];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= data_i;
    end
  end

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push_i && full_o)) else $error("item pushed into a full queue");
  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop_i && empty_o)) else $error("item popped from an empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QUEUE_CNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

// ----- hdl/nfd_back.sv -----
// Back end: one restoring divide step per stage, sign and special cases, result buffer.
`default_nettype none
module nfd_back import nfd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  work_t     q_data_i,
  input  wire logic q_empty_i,
  output logic      q_pop_o,
  output logic      empty_o,
  input  wire logic pop_i,
  output result_t   result_o
);

  function automatic work_t div_step(input work_t w);
    work_t            r;
    logic [REM_W-1:0] rem2;
    logic [REM_W-1:0] diff;
    logic             ge;
    r    = w;
    rem2 = {w.rem[REM_W-2:0], 1'b0};
    diff = rem2 - {1'b0, w.dvsr};
    ge   = (rem2 >= {1'b0, w.dvsr});
    r.rem = ge ? diff : rem2;
    r.quo = {w.quo[QUOTIENT_BITS-2:0], ge};
    return r;
  endfunction

  work_t                    st_r [QUOTIENT_BITS];
  logic [QUOTIENT_BITS-1:0] st_v_r;
  result_t                  fmt_r;
  result_t                  fmt_nxt;
  logic                     fmt_v_r;
  logic                     adv;

  result_t                  ob_mem_r [OB_DEPTH];
  logic [OB_PTR_W-1:0]      ob_wr_r, ob_rd_r;
  logic [OB_CNT_W-1:0]      ob_cnt_r;
  logic                     ob_full, ob_push, ob_pop;
  logic [QUOTIENT_W-1:0]    qmag;

  assign ob_full  = (ob_cnt_r == OB_CNT_W'(OB_DEPTH));
  assign empty_o  = (ob_cnt_r == '0);
  assign ob_push  = fmt_v_r && !ob_full;
  assign ob_pop   = pop_i && !empty_o;
  assign result_o = ob_mem_r[ob_rd_r];

  // The iteration stages stall together only when a finished item cannot leave.
  assign adv     = !(fmt_v_r && ob_full);
  assign q_pop_o = adv && !q_empty_i;

  always_comb begin
    qmag = st_r[QUOTIENT_BITS-1].den_zero ? DIV_ZERO_QUOTIENT
                                          : QUOTIENT_W'(st_r[QUOTIENT_BITS-1].quo);
    if (st_r[QUOTIENT_BITS-1].num_zero) begin
      fmt_nxt.quotient       = '0;
      fmt_nxt.shift_exponent = '0;
    end else begin
      fmt_nxt.quotient       = st_r[QUOTIENT_BITS-1].neg ? -qmag : qmag;
      fmt_nxt.shift_exponent = st_r[QUOTIENT_BITS-1].den_zero ? DIV_ZERO_SHIFT
                                                               : st_r[QUOTIENT_BITS-1].shift;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_v_r  <= '0;
      fmt_v_r <= 1'b0;
    end else if (adv) begin
      st_v_r  <= {st_v_r[QUOTIENT_BITS-2:0], !q_empty_i};
      fmt_v_r <= st_v_r[QUOTIENT_BITS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0] <= div_step(q_data_i);
      for (int k = 1; k < QUOTIENT_BITS; k++) begin
        st_r[k] <= div_step(st_r[k-1]);
      end
      fmt_r <= fmt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_wr_r  <= '0;
      ob_rd_r  <= '0;
      ob_cnt_r <= '0;
    end else begin
      if (ob_push) begin
        ob_wr_r <= ob_wr_r + 1'b1;
      end
      if (ob_pop) begin
        ob_rd_r <= ob_rd_r + 1'b1;
      end
      if (ob_push && !ob_pop) begin
        ob_cnt_r <= ob_cnt_r + 1'b1;
      end else if (ob_pop && !ob_push) begin
        ob_cnt_r <= ob_cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ob_push) begin
      ob_mem_r[ob_wr_r] <= fmt_r;
    end
  end

`ifndef SYNTHESIS
  a_ob_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ob_cnt_r <= OB_CNT_W'(OB_DEPTH)) else $error("result buffer count out of range");
  a_fmt_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (fmt_v_r && ob_full) |=> (fmt_v_r && $stable(fmt_r)))
    else $error("finished item lost while the result buffer was full");
  a_pipe_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(st_v_r)) else $error("divide stages moved during a stall");
`endif

endmodule
`default_nettype wire
